/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// token kinds, scan modes, keyword table and character class helpers
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int POSITION_BITS = 24;
  localparam int LENGTH_BITS   = 12;
  localparam int INLINE_CHARS  = 8;
  localparam int TEXT_BITS     = 64;
  localparam int KIND_BITS     = 5;
  localparam int KW_COUNT      = 11;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int TDATA_BITS    = 112;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  localparam logic [KIND_BITS-1:0] KIND_END      = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_BSLASH   = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_ARITH    = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_AMP      = 5'd16;
  localparam logic [KIND_BITS-1:0] KIND_PIPE     = 5'd17;
  localparam logic [KIND_BITS-1:0] KIND_CARET    = 5'd18;
  localparam logic [KIND_BITS-1:0] KIND_DOT      = 5'd19;
  localparam logic [KIND_BITS-1:0] KIND_COLON    = 5'd20;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 5'd21;
  localparam logic [KIND_BITS-1:0] KIND_LBRACK   = 5'd22;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 5'd23;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 5'd24;
  localparam logic [KIND_BITS-1:0] KIND_RBRACK   = 5'd25;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 5'd26;
  localparam logic [KIND_BITS-1:0] KIND_BANG     = 5'd27;
  localparam logic [KIND_BITS-1:0] KIND_EQUAL    = 5'd28;
  localparam logic [KIND_BITS-1:0] KIND_LESS     = 5'd29;
  localparam logic [KIND_BITS-1:0] KIND_GREATER  = 5'd30;
  localparam logic [KIND_BITS-1:0] KIND_INVALID  = 5'd31;

  // keywords packed first character in the low byte, so the literals read reversed
  localparam logic [TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'("fi"), 64'("tel"), 64'("tes"), 64'("dne"), 64'("esu"), 64'("esle"),
    64'("mune"), 64'("tsnoc"), 64'("egnar"), 64'("ssalc"), 64'("tcurts")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6
  };

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   len;
    logic                     ovf;
    logic [TEXT_BITS-1:0]     text;
  } scan_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]     kind;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   len;
    logic                     sat;
    logic [TEXT_BITS-1:0]     text;
    logic                     last;
  } tok_t;

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      8'h5c:                      k = KIND_BSLASH;
      8'h2b, 8'h2d, 8'h2a, 8'h2f: k = KIND_ARITH;
      8'h26:                      k = KIND_AMP;
      8'h7c:                      k = KIND_PIPE;
      8'h5e:                      k = KIND_CARET;
      8'h2e:                      k = KIND_DOT;
      8'h3a:                      k = KIND_COLON;
      8'h28:                      k = KIND_LPAREN;
      8'h5b:                      k = KIND_LBRACK;
      8'h7b:                      k = KIND_LBRACE;
      8'h29:                      k = KIND_RPAREN;
      8'h5d:                      k = KIND_RBRACK;
      8'h7d:                      k = KIND_RBRACE;
      8'h21:                      k = KIND_BANG;
      8'h3d:                      k = KIND_EQUAL;
      8'h3c:                      k = KIND_LESS;
      8'h3e:                      k = KIND_GREATER;
      default:                    k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [LENGTH_BITS-1:0] len,
                                                   input logic [TEXT_BITS-1:0] text,
                                                   input logic ovf);
    logic [KIND_BITS-1:0] k;
    k = KIND_IDENT;
    if (!ovf) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (len == LENGTH_BITS'(KW_LEN[i]) && text == KW_TEXT[i]) begin
          k = KIND_BITS'(int'(KIND_KEYWORD0) + i);
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/stt_step.sv */
// ----------------------------------------------------------------------------
// stt_step: one-byte scan step
// from the scan state and one byte, forms the next state and up to two tokens
// ----------------------------------------------------------------------------
`default_nettype none

module stt_step (
  input  stt_pkg::scan_t cur,
  input  logic [7:0]     char_code,
  input  logic           end_marker,
  output stt_pkg::scan_t nxt,
  output stt_pkg::tok_t  res0,
  output stt_pkg::tok_t  res1,
  output logic [1:0]     res_cnt
);
  import stt_pkg::*;

  always_comb begin
    logic                 is_dig;
    logic                 is_let;
    logic                 is_ws;
    logic                 cont;
    logic                 do_flush;
    logic                 new_v;
    logic [KIND_BITS-1:0] sk;
    tok_t                 flush_tok;
    tok_t                 new_tok;
    scan_t                cleared;

    is_dig = char_code inside {[8'h30:8'h39]};
    is_let = char_code inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    is_ws  = char_code inside {8'h20, 8'h09, 8'h0d, 8'h0a};
    sk     = single_kind(char_code);
    cont   = (cur.mode == MODE_NUMBER && is_dig) ||
             (cur.mode == MODE_IDENT && (is_let || is_dig));

    flush_tok.kind  = (cur.mode == MODE_NUMBER) ? KIND_NUMBER
                                                 : kw_kind(cur.len, cur.text, cur.ovf);
    flush_tok.start = cur.start;
    flush_tok.len   = cur.len;
    flush_tok.sat   = cur.ovf;
    flush_tok.text  = cur.text;
    flush_tok.last  = 1'b0;

    new_tok.kind  = KIND_INVALID;
    new_tok.start = cur.pos;
    new_tok.len   = LENGTH_BITS'(1);
    new_tok.sat   = 1'b0;
    new_tok.text  = TEXT_BITS'(char_code);
    new_tok.last  = 1'b1;

    cleared       = '0;
    cleared.mode  = MODE_IDLE;
    cleared.pos   = cur.pos + POSITION_BITS'(1);

    nxt      = cur;
    do_flush = 1'b0;
    new_v    = 1'b0;

    if (end_marker) begin
      do_flush      = (cur.mode != MODE_IDLE);
      new_v         = 1'b1;
      new_tok.kind  = KIND_END;
      new_tok.len   = '0;
      new_tok.text  = '0;
      nxt           = '0;
      nxt.mode      = MODE_IDLE;
    end else if (cont) begin
      for (int i = 0; i < INLINE_CHARS; i++) begin
        if (cur.len == LENGTH_BITS'(i)) begin
          nxt.text[8*i +: 8] = char_code;
        end
      end
      if (cur.len == LEN_MAX) begin
        nxt.ovf = 1'b1;
      end else begin
        nxt.len = cur.len + LENGTH_BITS'(1);
      end
      nxt.pos = cur.pos + POSITION_BITS'(1);
    end else begin
      do_flush = (cur.mode != MODE_IDLE);
      nxt      = cleared;
      if (is_ws) begin
        new_v = 1'b0;
      end else if (sk != KIND_END) begin
        new_v        = 1'b1;
        new_tok.kind = sk;
      end else if (is_dig || is_let) begin
        nxt.mode  = is_dig ? MODE_NUMBER : MODE_IDENT;
        nxt.start = cur.pos;
        nxt.len   = LENGTH_BITS'(1);
        nxt.text  = TEXT_BITS'(char_code);
      end else begin
        new_v = 1'b1;
      end
    end

    // flushed run always goes out ahead of the token this byte makes
    if (do_flush) begin
      res0      = flush_tok;
      res0.last = !new_v;
      res1      = new_tok;
      res_cnt   = new_v ? 2'd2 : 2'd1;
    end else begin
      res0    = new_tok;
      res1    = new_tok;
      res_cnt = new_v ? 2'd1 : 2'd0;
    end
  end

endmodule

`default_nettype wire

/* rtl/stt_out_fifo.sv */
// ----------------------------------------------------------------------------
// stt_out_fifo: token result queue
// small register queue taking up to two tokens a cycle and giving one
// ----------------------------------------------------------------------------
`default_nettype none

module stt_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [1:0]    push_cnt,
  input  stt_pkg::tok_t d0,
  input  stt_pkg::tok_t d1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::tok_t out_tok
);
  import stt_pkg::*;

  tok_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;
  logic [1:0]            n_in;
  logic                  pop;

  assign n_in      = push ? push_cnt : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_tok   = mem_r[rd_ptr_r];
  // two free slots so a double-token request always fits
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_in);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(n_in) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wr_ptr_r] <= d0;
    end
    if (n_in == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= d1;
    end
  end

endmodule

`default_nettype wire

/* rtl/source_text_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: streaming lexical tokenizer
// bytes in, tokens out with kind, position, length and leading text
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while the queue has room: each
// byte is scanned in the cycle it is accepted and its tokens (none, one or two)
// land in a four-entry result queue the next cycle. in_tready drops only while
// fewer than two queue slots are free, so a stalled consumer holds the input
// back; with the consumer ready the queue drains one token per cycle, and a byte
// that ends a pending run and also forms a token puts two tokens in the queue.
// An item with in_tuser set ends the text: it flushes the pending run, emits
// the end token and restarts positions at zero.
`default_nettype none

module source_text_tokenizer_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_code
  input  logic         in_tuser,   // end_marker
  output logic         out_tvalid,
  input  logic         out_tready,
  // token_kind, start_position, token_length, length_saturated, token_text, zero pad
  output logic [stt_pkg::TDATA_BITS-1:0] out_tdata,
  output logic         out_tlast   // last_of_run
);
  import stt_pkg::*;

  scan_t      scan_r;
  scan_t      scan_nxt;
  tok_t       res0;
  tok_t       res1;
  tok_t       head;
  logic [1:0] res_cnt;
  logic       accept;
  logic       room;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = room;

  stt_step u_step (
    .cur        (scan_r),
    .char_code  (in_tdata),
    .end_marker (in_tuser),
    .nxt        (scan_nxt),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt)
  );

  stt_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cnt  (res_cnt),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (head)
  );

  // all-zero state is idle with no pending run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (accept) begin
      scan_r <= scan_nxt;
    end
  end

  assign out_tdata = {6'd0, head.text, head.sat, head.len, head.start, head.kind};
  assign out_tlast = head.last;

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.mode == MODE_IDLE |-> scan_r.len == '0 && !scan_r.ovf && scan_r.text == '0)
    else $error("idle scan state holds a pending run");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.ovf |-> scan_r.len == LEN_MAX)
    else $error("length overflow flagged below the saturation value");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser |=> scan_r.pos == '0 && scan_r.mode == MODE_IDLE)
    else $error("end of text did not restart the scanner");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tuser |=> scan_r.pos == $past(scan_r.pos) + POSITION_BITS'(1))
    else $error("byte position did not advance by one");

endmodule

`default_nettype wire

/* test/source_text_tokenizer_top_tb.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_tb: self-checking bench for the byte tokenizer
// drives source bytes and end items, predicts every token in a scoreboard
// and compares each output token field by field in arrival order
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top_tb;
  import stt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // output word layout, token_kind in the lowest bits
  typedef struct packed {
    logic [5:0]               pad;
    logic [TEXT_BITS-1:0]     text;
    logic                     sat;
    logic [LENGTH_BITS-1:0]   len;
    logic [POSITION_BITS-1:0] start;
    logic [KIND_BITS-1:0]     kind;
  } token_word_t;

  class token_scoreboard;
    mode_t                    scan_mode;
    logic [POSITION_BITS-1:0] next_pos;
    logic [POSITION_BITS-1:0] run_start;
    logic [LENGTH_BITS-1:0]   run_len;
    logic                     run_sat;
    logic [TEXT_BITS-1:0]     run_text;
    tok_t                     expected_tokens[$];
    int                       mismatches;

    function new();
      scan_mode = MODE_IDLE;
      next_pos = '0;
      run_start = '0;
      run_len = '0;
      run_sat = 1'b0;
      run_text = '0;
      mismatches = 0;
    endfunction

    static function string keyword_word(int k);
      case (k)
        0: return "if";
        1: return "let";
        2: return "set";
        3: return "end";
        4: return "use";
        5: return "else";
        6: return "enum";
        7: return "const";
        8: return "range";
        9: return "class";
        default: return "struct";
      endcase
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic [KIND_BITS-1:0] punct_kind(logic [7:0] c);
      case (c)
        "\\":               return KIND_BSLASH;
        "+", "-", "*", "/": return KIND_ARITH;
        "&":                return KIND_AMP;
        "|":                return KIND_PIPE;
        "^":                return KIND_CARET;
        ".":                return KIND_DOT;
        ":":                return KIND_COLON;
        "(":                return KIND_LPAREN;
        "[":                return KIND_LBRACK;
        "{":                return KIND_LBRACE;
        ")":                return KIND_RPAREN;
        "]":                return KIND_RBRACK;
        "}":                return KIND_RBRACE;
        "!":                return KIND_BANG;
        "=":                return KIND_EQUAL;
        "<":                return KIND_LESS;
        ">":                return KIND_GREATER;
        default:            return KIND_END;
      endcase
    endfunction

    function logic [KIND_BITS-1:0] word_kind();
      string             w;
      logic [TEXT_BITS-1:0] word_bits;
      if (run_sat) return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
        w = keyword_word(k);
        word_bits = '0;
        for (int i = 0; i < w.len(); i++) word_bits |= TEXT_BITS'(w[i]) << (8 * i);
        if (run_len == LENGTH_BITS'(w.len()) && run_text == word_bits)
          return KIND_BITS'(int'(KIND_KEYWORD0) + k);
      end
      return KIND_IDENT;
    endfunction

    function void push_token(logic [KIND_BITS-1:0] kind, logic [POSITION_BITS-1:0] start,
                             logic [LENGTH_BITS-1:0] len, logic sat,
                             logic [TEXT_BITS-1:0] text);
      tok_t t;
      t.kind = kind;
      t.start = start;
      t.len = len;
      t.sat = sat;
      t.text = text;
      t.last = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void flush_run();
      if (scan_mode == MODE_IDLE) return;
      push_token(scan_mode == MODE_NUMBER ? KIND_NUMBER : word_kind(),
                 run_start, run_len, run_sat, run_text);
      scan_mode = MODE_IDLE;
      run_start = '0;
      run_len = '0;
      run_sat = 1'b0;
      run_text = '0;
    endfunction

    function void open_run(mode_t m, logic [7:0] c);
      scan_mode = m;
      run_start = next_pos;
      run_len = LENGTH_BITS'(1);
      run_sat = 1'b0;
      run_text = TEXT_BITS'(c);
    endfunction

    function void extend_run(logic [7:0] c);
      if (run_len < INLINE_CHARS) run_text |= TEXT_BITS'(c) << (8 * run_len);
      if (run_len == LEN_MAX) run_sat = 1'b1;
      else run_len++;
    endfunction

    // predicts the tokens caused by one accepted request
    function void note_request(logic [7:0] c, logic end_of_text);
      int               before_count;
      logic [KIND_BITS-1:0] pk;
      before_count = expected_tokens.size();
      if (end_of_text) begin
        flush_run();
        push_token(KIND_END, next_pos, '0, 1'b0, '0);
        next_pos = '0;
      end else begin
        pk = punct_kind(c);
        if (scan_mode == MODE_NUMBER && is_digit(c)) begin
          extend_run(c);
        end else if (scan_mode == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
          extend_run(c);
        end else begin
          flush_run();
          if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
            // whitespace only separates
          end else if (pk != KIND_END) begin
            push_token(pk, next_pos, LENGTH_BITS'(1), 1'b0, TEXT_BITS'(c));
          end else if (is_digit(c)) begin
            open_run(MODE_NUMBER, c);
          end else if (is_letter(c)) begin
            open_run(MODE_IDENT, c);
          end else begin
            push_token(KIND_INVALID, next_pos, LENGTH_BITS'(1), 1'b0, TEXT_BITS'(c));
          end
        end
        next_pos = next_pos + POSITION_BITS'(1);
      end
      if (expected_tokens.size() > before_count) expected_tokens[$].last = 1'b1;
    endfunction

    function void check_token(logic [TDATA_BITS-1:0] data, logic last);
      token_word_t got;
      tok_t        exp_tok;
      got = token_word_t'(data);
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d start %0d len %0d sat %0d text %h last %0d",
                   got.kind, got.start, got.len, got.sat, got.text, last);
        return;
      end
      exp_tok = expected_tokens.pop_front();
      if (got.kind !== exp_tok.kind || got.start !== exp_tok.start ||
          got.len !== exp_tok.len || got.sat !== exp_tok.sat ||
          got.text !== exp_tok.text || last !== exp_tok.last || got.pad !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch: expected kind %0d start %0d len %0d sat %0d text %h last %0d",
                   exp_tok.kind, exp_tok.start, exp_tok.len, exp_tok.sat, exp_tok.text,
                   exp_tok.last);
          $display("                got      kind %0d start %0d len %0d sat %0d text %h last %0d",
                   got.kind, got.start, got.len, got.sat, got.text, last);
        end
      end
    endfunction

    function int pending_count();
      return expected_tokens.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // char_code
  logic                  in_tuser;   // end_marker
  logic                  out_tvalid;
  logic                  out_tready;
  // token_kind, start_position, token_length, length_saturated, token_text, zero pad
  logic [TDATA_BITS-1:0] out_tdata;
  logic                  out_tlast;  // last_of_run

  token_scoreboard sb = new();
  int              src_idle_pct = 0;
  int              sink_idle_pct = 0;
  int              phase = 0;
  int              items_sent = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  int unsigned     cycle_count = 0;

  source_text_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("source_text_tokenizer_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
    end
  end

  // consumer side, with one long hold-off early in the last phase
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        out_tready <= 1'b0;
      end else if (phase == 2 && !hold_done) begin
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task send_item(logic [7:0] c, logic end_of_text);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= end_of_text;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_punct();
    string ops;
    ops = "\\+-*/&|^.:([{)]}!=<>";
    return ops[$urandom_range(0, ops.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0d;
      default: return 8'h0a;
    endcase
  endfunction

  task send_separator();
    if ($urandom_range(0, 2) == 0) send_item(rand_punct(), 1'b0);
    else send_item(rand_space(), 1'b0);
  endtask

  task send_piece();
    int    r;
    int    n;
    string w;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_text(token_scoreboard::keyword_word($urandom_range(0, KW_COUNT - 1)));
      if ($urandom_range(0, 9) < 7) send_separator();
    end else if (r < 25) begin
      // near misses of keywords
      w = token_scoreboard::keyword_word($urandom_range(0, KW_COUNT - 1));
      case ($urandom_range(0, 2))
        0: w = w.substr(0, w.len() - 2);
        1: w = {w, string'(rand_letter())};
        default: w[0] = w[0] - 8'h20;
      endcase
      send_text(w);
      send_separator();
    end else if (r < 40) begin
      n = $urandom_range(1, 12);
      send_item(rand_letter(), 1'b0);
      for (int i = 1; i < n; i++)
        send_item($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
    end else if (r < 52) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_item(rand_digit(), 1'b0);
    end else if (r < 66) begin
      send_item(rand_punct(), 1'b0);
    end else if (r < 76) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_item(rand_space(), 1'b0);
    end else if (r < 95) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task send_long_run(bit ident, int n);
    if (ident) begin
      send_text("struct");
      for (int i = 6; i < n; i++)
        send_item($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
    end else begin
      for (int i = 0; i < n; i++) send_item(rand_digit(), 1'b0);
    end
    send_item(" ", 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct = 12;
    sink_idle_pct = 60;
    // number then identifier, keyword, every bracket and operator class
    send_text("7x9 if\\&|^.:([{)]}!=<>+");
    send_item(8'h09, 1'b0);
    send_item(8'h0d, 1'b0);
    send_item(8'h0a, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);

    while (items_sent < 260) send_piece();
    send_item(8'h00, 1'b1);

    phase = 1;
    src_idle_pct = 60;
    sink_idle_pct = 12;
    while (items_sent < 490) send_piece();
    send_item(8'h00, 1'b1);

    phase = 2;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    while (items_sent < 730) send_piece();
    // runs at and past the saturating length
    send_long_run(1'b0, 4095);
    send_long_run(1'b0, 4096);
    send_long_run(1'b1, 4095);
    send_long_run(1'b1, 4100);
    send_text("if 5");
    send_item(8'h00, 1'b1);
    in_tvalid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("source_text_tokenizer_top verification clean");
    end else begin
      $display("source_text_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
